### hdl/rcom_pkg.sv
// Types and constants shared by the offboard command mux.
// No dependencies; every other file but rcom_chan_if imports this package.
`timescale 1ns / 1ps
package rcom_pkg;

	// Input item word
	typedef struct packed {
		logic               kind;
		logic [31:0]        now_us;
		logic [31:0]        now_ms;
		logic signed [15:0] stick_roll;
		logic signed [15:0] stick_pitch;
		logic signed [15:0] stick_yaw;
		logic [14:0]        stick_throttle;
		logic [7:0]         flags;
		logic [1:0]         off_channel;
		logic               off_active;
		logic [1:0]         off_type;
		logic signed [19:0] off_value;
	} item_t;

	// Result word
	typedef struct packed {
		logic               updated;
		logic signed [19:0] roll_out;
		logic signed [19:0] pitch_out;
		logic signed [19:0] yaw_out;
		logic signed [19:0] throttle_out;
		logic [7:0]         types_out;
		logic [3:0]         actives_out;
		logic               pilot_override;
	} result_t;

	// Configuration write word
	typedef struct packed {
		logic [2:0]  index;
		logic [47:0] data;
	} cfg_t;

	// Item class decided by the front end
	typedef enum logic [1:0] {
		CLS_LOAD,
		CLS_FAILSAFE,
		CLS_IDLE,
		CLS_MUX
	} cls_t;

	typedef struct packed {
		cls_t  cls;
		item_t item;
	} queue_entry_t;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// Flag bit positions
	localparam int unsigned FLG_FAILSAFE   = 0;
	localparam int unsigned FLG_NEW_CMD    = 1;
	localparam int unsigned FLG_ATT_MAPPED = 2;
	localparam int unsigned FLG_ATT_ANGLE  = 3;
	localparam int unsigned FLG_AOVR_MAP   = 4;
	localparam int unsigned FLG_AOVR_ON    = 5;
	localparam int unsigned FLG_TOVR_MAP   = 6;
	localparam int unsigned FLG_TOVR_ON    = 7;

	// Mode bit positions
	localparam int unsigned MODE_FIXED_WING = 0;
	localparam int unsigned MODE_ANGLE_DEF  = 1;
	localparam int unsigned MODE_MIN_THR    = 2;

	// Control type codes
	localparam logic [1:0] TYP_RATE     = 2'd0;
	localparam logic [1:0] TYP_ANGLE    = 2'd1;
	localparam logic [1:0] TYP_THROTTLE = 2'd2;
	localparam logic [1:0] TYP_PASS     = 2'd3;

	// Register indexes
	localparam logic [2:0] CFG_MODE_BITS   = 3'd0;
	localparam logic [2:0] CFG_ANGLE_LIM   = 3'd1;
	localparam logic [2:0] CFG_RATE_LIM    = 3'd2;
	localparam logic [2:0] CFG_OVR_DEV     = 3'd3;
	localparam logic [2:0] CFG_OVR_LAG     = 3'd4;
	localparam logic [2:0] CFG_FS_THROTTLE = 3'd5;

	// Register reset values
	localparam logic [2:0]  RST_MODE_BITS   = 3'd0;
	localparam logic [31:0] RST_ANGLE_LIM   = 32'd211029140;
	localparam logic [47:0] RST_RATE_LIM    = 48'd26513675989565;
	localparam logic [14:0] RST_OVR_DEV     = 15'd3277;
	localparam logic [15:0] RST_OVR_LAG     = 16'd1000;
	localparam logic [14:0] RST_FS_THROTTLE = 15'd9830;

	// Offboard input goes stale after this many microseconds
	localparam logic [31:0] TIMEOUT_US = 32'd100000;

	// Failsafe types: roll angle, pitch angle, yaw rate, throttle
	localparam logic [7:0] FAILSAFE_TYPES = {TYP_THROTTLE, TYP_RATE, TYP_ANGLE, TYP_ANGLE};

endpackage

### hdl/rcom_chan_if.sv
// Valid/ready channel carrying one payload word of a chosen type.
// Depends on nothing; payload types come from rcom_pkg at instantiation.
`timescale 1ns / 1ps
interface rcom_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/rcom_front.sv
// Front end: accept item words and tag each with its class.
// Depends on rcom_pkg and rcom_chan_if.
`timescale 1ns / 1ps
module rcom_front (
	rcom_chan_if.sink            item,
	input  logic                 full,
	output logic                 push,
	output rcom_pkg::queue_entry_t push_entry
);
	import rcom_pkg::*;

	assign item.ready = !full;
	assign push       = item.valid && !full;

	always_comb begin
		push_entry.item = item.payload;
		if (item.payload.kind == KIND_LOAD) begin
			push_entry.cls = CLS_LOAD;
		end else if (item.payload.flags[FLG_FAILSAFE]) begin
			push_entry.cls = CLS_FAILSAFE;
		end else if (!item.payload.flags[FLG_NEW_CMD]) begin
			push_entry.cls = CLS_IDLE;
		end else begin
			push_entry.cls = CLS_MUX;
		end
	end
endmodule

### hdl/rcom_queue.sv
// Short queue of classified items between front end and back end.
// Depends on rcom_pkg.
`timescale 1ns / 1ps
module rcom_queue #(
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rcom_pkg::queue_entry_t push_entry,
	output logic                   full,
	output logic                   head_valid,
	output rcom_pkg::queue_entry_t head_entry,
	input  logic                   pop
);
	import rcom_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### hdl/rcom_back.sv
// Back end: configuration registers, offboard state, channel mux and
// the output register. Depends on rcom_pkg and rcom_chan_if.
`timescale 1ns / 1ps
module rcom_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  rcom_pkg::queue_entry_t head_entry,
	output logic                   pop,
	rcom_chan_if.sink              cfg,
	rcom_chan_if.source            result
);
	import rcom_pkg::*;

	// stick * limit / 4096, half rounded up, saturated to 20 bits
	function automatic logic signed [19:0] scale_stick(input logic signed [15:0] s,
			input logic [15:0] lim);
		logic signed [32:0] p;
		logic signed [20:0] r;
		p = 33'(s) * $signed({17'd0, lim});
		p = p + 33'sd2048;
		r = 21'(p >>> 12);
		if (r > 21'sd524287) begin
			return 20'sd524287;
		end else if (r < -21'sd524288) begin
			return -20'sd524288;
		end else begin
			return 20'(r);
		end
	endfunction

	// Configuration
	logic [2:0]  mode_q;
	logic [31:0] angle_lim_q;
	logic [47:0] rate_lim_q;
	logic [14:0] ovr_dev_q;
	logic [15:0] ovr_lag_q;
	logic [14:0] fs_thr_q;

	// Offboard and override state
	logic signed [19:0] off_val_q [4];
	logic [1:0]         off_type_q [4];
	logic [3:0]         off_act_q;
	logic [31:0]        stamp_us_q;
	logic [31:0]        ovr_stamp_q [3];
	logic               ovr_flag_q;

	result_t res_q;
	logic    res_valid_q;

	item_t              it;
	logic               out_free;
	logic               fire;
	logic               timed_out;
	logic [3:0]         act_eff;
	logic               angle;
	logic               sw_att;
	logic               sw_thr;
	logic signed [15:0] stick [3];
	logic signed [19:0] val [4];
	logic [1:0]         typ [4];
	logic [3:0]         act;
	logic [3:0]         pilot;
	logic [2:0]         restamp;
	logic [2:0]         in_lag;
	logic [2:0]         big;
	logic [16:0]        mag [3];
	logic signed [16:0] sx [3];
	result_t            res_n;

	assign it       = head_entry.item;
	assign out_free = !res_valid_q || result.ready;
	assign fire     = head_valid && ((head_entry.cls == CLS_LOAD) || out_free);
	assign pop      = fire;

	assign cfg.ready      = 1'b1;
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	assign timed_out = (32'(it.now_us - stamp_us_q) > TIMEOUT_US);
	assign act_eff   = timed_out ? 4'b0000 : off_act_q;
	assign sw_att    = it.flags[FLG_AOVR_MAP] && it.flags[FLG_AOVR_ON];
	assign sw_thr    = it.flags[FLG_TOVR_MAP] && it.flags[FLG_TOVR_ON];
	assign angle     = it.flags[FLG_ATT_MAPPED] ? it.flags[FLG_ATT_ANGLE] : mode_q[MODE_ANGLE_DEF];

	assign stick[0] = it.stick_roll;
	assign stick[1] = it.stick_pitch;
	assign stick[2] = it.stick_yaw;

	// Pilot command, channel mux and result word
	always_comb begin
		if (mode_q[MODE_FIXED_WING]) begin
			for (int i = 0; i < 3; i++) begin
				val[i] = 20'(stick[i]);
				typ[i] = TYP_PASS;
			end
		end else begin
			if (angle) begin
				val[0] = scale_stick(stick[0], angle_lim_q[15:0]);
				val[1] = scale_stick(stick[1], angle_lim_q[31:16]);
				typ[0] = TYP_ANGLE;
				typ[1] = TYP_ANGLE;
			end else begin
				val[0] = scale_stick(stick[0], rate_lim_q[15:0]);
				val[1] = scale_stick(stick[1], rate_lim_q[31:16]);
				typ[0] = TYP_RATE;
				typ[1] = TYP_RATE;
			end
			val[2] = scale_stick(stick[2], rate_lim_q[47:32]);
			typ[2] = TYP_RATE;
		end
		val[3] = $signed({5'd0, it.stick_throttle});
		typ[3] = TYP_THROTTLE;

		for (int i = 0; i < 3; i++) begin
			sx[i]      = 17'(stick[i]);
			mag[i]     = sx[i][16] ? 17'(-sx[i]) : 17'(sx[i]);
			in_lag[i]  = (32'(it.now_ms - ovr_stamp_q[i]) < {16'd0, ovr_lag_q});
			big[i]     = (mag[i] > {2'd0, ovr_dev_q});
			restamp[i] = !sw_att && !in_lag[i] && big[i];
			pilot[i]   = sw_att || in_lag[i] || big[i] || !act_eff[i];
		end
		if (sw_thr || !act_eff[3]) begin
			pilot[3] = 1'b1;
		end else begin
			pilot[3] = mode_q[MODE_MIN_THR] && (val[3] < off_val_q[3]);
		end

		for (int i = 0; i < 4; i++) begin
			if (pilot[i]) begin
				act[i] = 1'b1;
			end else begin
				val[i] = off_val_q[i];
				typ[i] = off_type_q[i];
				act[i] = act_eff[i];
			end
		end

		res_n = '0;
		case (head_entry.cls)
			CLS_FAILSAFE: begin
				res_n.updated        = 1'b1;
				res_n.throttle_out   = $signed({5'd0, fs_thr_q});
				res_n.types_out      = FAILSAFE_TYPES;
				res_n.actives_out    = 4'hF;
				res_n.pilot_override = ovr_flag_q;
			end
			CLS_MUX: begin
				res_n.updated        = 1'b1;
				res_n.roll_out       = val[0];
				res_n.pitch_out      = val[1];
				res_n.yaw_out        = val[2];
				res_n.throttle_out   = val[3];
				res_n.types_out      = {typ[3], typ[2], typ[1], typ[0]};
				res_n.actives_out    = act;
				res_n.pilot_override = |pilot;
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE_BITS;
			angle_lim_q <= RST_ANGLE_LIM;
			rate_lim_q  <= RST_RATE_LIM;
			ovr_dev_q   <= RST_OVR_DEV;
			ovr_lag_q   <= RST_OVR_LAG;
			fs_thr_q    <= RST_FS_THROTTLE;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				CFG_MODE_BITS:   mode_q      <= cfg.payload.data[2:0];
				CFG_ANGLE_LIM:   angle_lim_q <= cfg.payload.data[31:0];
				CFG_RATE_LIM:    rate_lim_q  <= cfg.payload.data;
				CFG_OVR_DEV:     ovr_dev_q   <= cfg.payload.data[14:0];
				CFG_OVR_LAG:     ovr_lag_q   <= cfg.payload.data[15:0];
				CFG_FS_THROTTLE: fs_thr_q    <= cfg.payload.data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Offboard state, override stamps, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				off_val_q[i]  <= '0;
				off_type_q[i] <= TYP_RATE;
			end
			for (int i = 0; i < 3; i++) begin
				ovr_stamp_q[i] <= '0;
			end
			off_act_q   <= '0;
			stamp_us_q  <= '0;
			ovr_flag_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire && (head_entry.cls == CLS_LOAD)) begin
				off_val_q[it.off_channel]  <= it.off_value;
				off_type_q[it.off_channel] <= it.off_type;
				off_act_q[it.off_channel]  <= it.off_active;
				stamp_us_q                 <= it.now_us;
			end
			if (fire && (head_entry.cls == CLS_MUX)) begin
				off_act_q  <= act_eff;
				ovr_flag_q <= |pilot;
				for (int i = 0; i < 3; i++) begin
					if (restamp[i]) begin
						ovr_stamp_q[i] <= it.now_ms;
					end
				end
			end
			if (fire && (head_entry.cls != CLS_LOAD)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (head_entry.cls != CLS_LOAD)) begin
			res_q <= res_n;
		end
	end
endmodule

### hdl/rc_offboard_command_mux_top.sv
// Offboard command mux: one result word per tick word, held in the queue and
// then the output register; one item word per cycle while output is not stalled.
// Load words update offboard state and give no result word.
// The back end's mux logic is combinational and feeds the output register.
// arst_n clears the queue and output valid, restores register defaults and
// resets all offboard and override state.
`timescale 1ns / 1ps
module rc_offboard_command_mux_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	rcom_chan_if.sink   item,
	rcom_chan_if.sink   cfg,
	rcom_chan_if.source result
);
	import rcom_pkg::*;

	// Front end to queue
	logic         push;
	logic         full;
	queue_entry_t push_entry;

	// Queue to back end
	logic         head_valid;
	logic         pop;
	queue_entry_t head_entry;

	// Accept item words while the queue has room and tag each one
	// as load, failsafe, idle or mux tick.
	rcom_front u_front (
		.item       (item),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Hold classified words so the front end keeps accepting while the
	// output side stalls.
	rcom_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// Advance one word per cycle: loads always drain, ticks drain when the
	// output register is free or being emptied in the same cycle.
	rcom_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.cfg        (cfg),
		.result     (result)
	);
endmodule
